// File: hw/rtl/bt_pkg.sv
// Shared widths and codes for the boundary-tag allocator.
`timescale 1ns / 1ps
`default_nettype none
package bt_pkg;
  localparam int OPCODE_W    = 1;
  localparam int SIZE_W      = 12;
  localparam int ADDR_W      = 12;
  localparam int HEAP_SIZE_W = 13;
  localparam logic [HEAP_SIZE_W-1:0] HEAP_SIZE_RESET = 13'd4096;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;
endpackage
`default_nettype wire

// File: hw/rtl/bt_req_if.sv
// Request channel: opcode, size and address.
`timescale 1ns / 1ps
`default_nettype none
interface bt_req_if;
  logic                           valid;
  logic                           ready;
  bt_pkg::opcode_t                opcode;
  logic [bt_pkg::SIZE_W-1:0]      request_size;
  logic [bt_pkg::ADDR_W-1:0]      user_address;
  modport source (output valid, opcode, request_size, user_address, input ready);
  modport sink   (input valid, opcode, request_size, user_address, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bt_rsp_if.sv
// Response channel: granted address and success flag.
`timescale 1ns / 1ps
`default_nettype none
interface bt_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [bt_pkg::ADDR_W-1:0] granted_address;
  logic                      success;
  modport source (output valid, granted_address, success, input ready);
  modport sink   (input valid, granted_address, success, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bt_cfg_if.sv
// Configuration write channel for heap_size.
`timescale 1ns / 1ps
`default_nettype none
interface bt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bt_pkg::HEAP_SIZE_W-1:0] heap_size;
  modport source (output valid, heap_size, input ready);
  modport sink   (input valid, heap_size, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bt_ram.sv
// Tag memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module bt_ram #(
  parameter int AW = 12,
  parameter int DW = 14
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/boundary_tag_first_fit_allocator.sv
// Boundary-tag first-fit heap allocator with coalescing on free.
// Each request walks the heap block by block: an allocate reads each block from
// the heap start until one fits, then writes the tags and may split it; a free
// walks blocks up to the target, marks it free, merges each free lower neighbor
// and then each free upper neighbor, and closes. The pace is set by the single
// read port of the tag memories and the one shared tag writer. The request
// channel is not ready while a request is in work. A heap_size write, and
// reset, reformat the heap.
`timescale 1ns / 1ps
`default_nettype none
module boundary_tag_first_fit_allocator #(
  parameter int HEAP_BYTES      = 4096,
  parameter int TAG_BYTES       = 16,
  parameter int MIN_SPLIT_BYTES = 16
) (
  input wire logic clk,
  input wire logic rst,
  bt_req_if.sink   req,
  bt_rsp_if.source rsp,
  bt_cfg_if.sink   cfg
);
  localparam int AW = $clog2(HEAP_BYTES);
  localparam int VW = AW + 1;
  localparam int CW = (VW + 1 > 14) ? VW + 1 : 14;
  localparam int GW = (CW > bt_pkg::ADDR_W) ? CW : bt_pkg::ADDR_W;
  localparam logic [CW-1:0] T1   = CW'(TAG_BYTES);
  localparam logic [CW-1:0] T2   = CW'(2 * TAG_BYTES);
  localparam logic [CW-1:0] MINS = CW'(MIN_SPLIT_BYTES);
  localparam logic [CW-1:0] HB   = CW'(HEAP_BYTES);

  typedef enum logic [3:0] {
    S_FMT, S_IDLE, A_ADDR, A_CHK, A_SPLIT, F_ADDR, F_CHK, F_MARK,
    P_TEST, P_CHK, P_HADDR, P_HCHK, N_TEST, N_ADDR, N_CHK, S_OUT
  } state_t;

  state_t                         state;
  logic [bt_pkg::HEAP_SIZE_W-1:0] heap_size;
  logic [CW-1:0] span, ptr, cur, cur_size, req_size, target, grant;
  logic          ok;

  logic          hdr_we;
  logic [VW:0]   hdr_wdata, hdr_rdata, tail_rdata;
  logic [CW-1:0] sb_h, sb_size, tail_waddr;
  logic          sb_free;

  logic [CW-1:0] rd_size, tl_size, hs, span_c;
  logic          rd_free;
  logic [CW-1:0] whole, low, nh, nxt, ncur, tail_t, p_hdr, end_p, end_n;
  logic          fit, split;

  assign rd_free = hdr_rdata[VW];
  assign rd_size = CW'(hdr_rdata[VW-1:0]);
  assign tl_size = CW'(tail_rdata[VW-1:0]);
  assign hs      = (CW'(heap_size) > HB) ? HB : CW'(heap_size);
  assign span_c  = (hs < T2) ? '0 : hs;

  assign whole  = req_size + T2;
  assign fit    = rd_free && (rd_size >= req_size);
  assign split  = (rd_size > whole) && ((rd_size - whole) >= MINS);
  assign low    = rd_size - whole;
  assign nh     = ptr + T2 + low;
  assign nxt    = ptr + T2 + rd_size;
  assign ncur   = cur + T2 + cur_size;
  assign tail_t = cur - T1;
  assign p_hdr  = tail_t - tl_size - T1;
  assign end_p  = cur + T1 + cur_size;
  assign end_n  = ptr + T1 + rd_size;

  // Shared block writer: header at sb_h, tail after the payload.
  always_comb begin
    hdr_we  = 1'b0;
    sb_h    = ptr;
    sb_size = rd_size;
    sb_free = 1'b1;
    case (state)
      S_FMT: begin
        hdr_we  = (span_c != '0);
        sb_h    = '0;
        sb_size = span_c - T2;
      end
      A_CHK: begin
        hdr_we  = fit;
        sb_size = split ? low : rd_size;
        sb_free = split;
      end
      A_SPLIT: begin
        hdr_we  = 1'b1;
        sb_size = req_size;
        sb_free = 1'b0;
      end
      F_MARK: begin
        hdr_we  = 1'b1;
        sb_h    = cur;
        sb_size = cur_size;
      end
      P_HCHK: begin
        hdr_we  = rd_free;
        sb_size = end_p - ptr - T1;
      end
      N_CHK: begin
        hdr_we  = rd_free;
        sb_h    = cur;
        sb_size = end_n - cur - T1;
      end
      default: ;
    endcase
  end

  assign tail_waddr = sb_h + T1 + sb_size;
  assign hdr_wdata  = {sb_free, sb_size[VW-1:0]};

  bt_ram #(.AW(AW), .DW(VW + 1)) u_hdr (
    .clk   (clk),
    .we    (hdr_we),
    .waddr (sb_h[AW-1:0]),
    .wdata (hdr_wdata),
    .raddr (ptr[AW-1:0]),
    .rdata (hdr_rdata)
  );

  bt_ram #(.AW(AW), .DW(VW + 1)) u_tail (
    .clk   (clk),
    .we    (hdr_we),
    .waddr (tail_waddr[AW-1:0]),
    .wdata (hdr_wdata),
    .raddr (tail_t[AW-1:0]),
    .rdata (tail_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FMT;
      heap_size <= bt_pkg::HEAP_SIZE_RESET;
      span      <= '0;
      ok        <= 1'b0;
      grant     <= '0;
    end else if (cfg.valid && cfg.ready) begin
      heap_size <= cfg.heap_size;
      state     <= S_FMT;
    end else begin
      case (state)
        S_FMT: begin
          span  <= span_c;
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid && req.ready) begin
            req_size <= CW'(req.request_size);
            target   <= CW'(req.user_address) - T1;
            ptr      <= '0;
            grant    <= '0;
            ok       <= 1'b0;
            if (span == '0) begin
              state <= S_OUT;
            end else if (req.opcode == bt_pkg::OP_ALLOC) begin
              state <= A_ADDR;
            end else if (CW'(req.user_address) < T1) begin
              state <= S_OUT;
            end else begin
              state <= F_ADDR;
            end
          end
        end
        A_ADDR: state <= A_CHK;
        A_CHK: begin
          if (fit) begin
            if (split) begin
              grant <= nh + T1;
              ptr   <= nh;
              state <= A_SPLIT;
            end else begin
              grant <= ptr + T1;
              ok    <= 1'b1;
              state <= S_OUT;
            end
          end else if (nxt >= span) begin
            state <= S_OUT;
          end else begin
            ptr   <= nxt;
            state <= A_ADDR;
          end
        end
        A_SPLIT: begin
          ok    <= 1'b1;
          state <= S_OUT;
        end
        F_ADDR: state <= F_CHK;
        F_CHK: begin
          if (ptr == target) begin
            cur      <= ptr;
            cur_size <= rd_size;
            state    <= F_MARK;
          end else if (nxt >= span) begin
            state <= S_OUT;
          end else begin
            ptr   <= nxt;
            state <= F_ADDR;
          end
        end
        F_MARK: begin
          ok    <= 1'b1;
          state <= P_TEST;
        end
        P_TEST: state <= (cur < T2) ? N_TEST : P_CHK;
        P_CHK: begin
          if (tl_size + T1 > tail_t) begin
            state <= N_TEST;
          end else begin
            ptr   <= p_hdr;
            state <= P_HADDR;
          end
        end
        P_HADDR: state <= P_HCHK;
        P_HCHK: begin
          if (rd_free) begin
            cur      <= ptr;
            cur_size <= end_p - ptr - T1;
            state    <= P_TEST;
          end else begin
            state <= N_TEST;
          end
        end
        N_TEST: begin
          if (ncur >= span) begin
            state <= S_OUT;
          end else begin
            ptr   <= ncur;
            state <= N_ADDR;
          end
        end
        N_ADDR: state <= N_CHK;
        N_CHK: begin
          if (rd_free) begin
            cur_size <= end_n - cur - T1;
            state    <= N_TEST;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic [GW-1:0] grant_ext;
  assign grant_ext = ok ? GW'(grant) : '0;

  assign req.ready           = (state == S_IDLE) && !cfg.valid;
  assign cfg.ready           = 1'b1;
  assign rsp.valid           = (state == S_OUT);
  assign rsp.granted_address = grant_ext[bt_pkg::ADDR_W-1:0];
  assign rsp.success         = ok;
endmodule
`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for the boundary-tag first-fit heap allocator.
`timescale 1ns / 1ps
module tb;
  localparam int HEAP_MAX    = 4096;
  localparam int TAG         = 16;
  localparam int MIN_SPLIT   = 16;
  localparam int WDOG_LIMIT  = 20000;
  localparam int DRAIN_WAIT  = 800;
  localparam int N_DIRECTED  = 18;

  typedef struct {
    logic [bt_pkg::ADDR_W-1:0] granted;
    logic                      ok;
  } grant_t;

  typedef struct {
    bt_pkg::opcode_t           op;
    logic [bt_pkg::SIZE_W-1:0] size;
    logic [bt_pkg::ADDR_W-1:0] addr;
    bit                        fixed;
    logic [bt_pkg::ADDR_W-1:0] granted;
    logic                      ok;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bt_req_if req ();
  bt_rsp_if rsp ();
  bt_cfg_if cfg ();

  boundary_tag_first_fit_allocator uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Heap shadow: bit 12 is the free flag, bits 11:0 the payload size.
  logic [12:0] hdr_tag [0:HEAP_MAX-1];
  logic [12:0] tl_tag  [0:HEAP_MAX-1];
  int          heap_span;

  grant_t      pending_grants[$];
  logic [11:0] live_blocks[$];
  int          mismatches = 0;
  int          idle_pct   = 0;
  int          stall_pct  = 0;
  int          hold_left  = 0;
  int          quiet_cycles = 0;
  stim_row_t   directed [N_DIRECTED];

  function automatic int blk_size(int h);
    return (h < HEAP_MAX) ? int'(hdr_tag[h][11:0]) : 0;
  endfunction

  function automatic bit blk_free(int h);
    return (h < HEAP_MAX) ? hdr_tag[h][12] : 1'b0;
  endfunction

  function automatic void put_block(int h, int payload, bit fr);
    int t;
    t = h + TAG + payload;
    if (h < HEAP_MAX) hdr_tag[h] = {fr, payload[11:0]};
    if (t < HEAP_MAX) tl_tag[t] = {fr, payload[11:0]};
  endfunction

  function automatic void format_heap(logic [bt_pkg::HEAP_SIZE_W-1:0] hs);
    for (int i = 0; i < HEAP_MAX; i++) begin
      hdr_tag[i] = '0;
      tl_tag[i]  = '0;
    end
    heap_span = (hs > HEAP_MAX) ? HEAP_MAX : int'(hs);
    if (heap_span < 2 * TAG) heap_span = 0;
    else put_block(0, heap_span - 2 * TAG, 1'b1);
  endfunction

  function automatic int next_blk(int h);
    int n;
    n = h + 2 * TAG + blk_size(h);
    return (n >= heap_span) ? heap_span : n;
  endfunction

  function automatic bit alloc_block(int need, output int granted);
    int h, have, whole, low, nh;
    h = 0;
    granted = 0;
    while (h < heap_span) begin
      have = blk_size(h);
      if (blk_free(h) && have >= need) begin
        whole = need + 2 * TAG;
        if (have > whole && have - whole >= MIN_SPLIT) begin
          low = have - whole;
          nh  = h + 2 * TAG + low;
          put_block(h, low, 1'b1);
          put_block(nh, need, 1'b0);
          granted = nh + TAG;
        end else begin
          put_block(h, have, 1'b0);
          granted = h + TAG;
        end
        return 1'b1;
      end
      h = next_blk(h);
    end
    return 1'b0;
  endfunction

  function automatic bit release_block(int a);
    int target, h, cur, t, s, p, n;
    if (a < TAG || heap_span == 0) return 1'b0;
    target = a - TAG;
    h = 0;
    while (h < heap_span && h != target) h = next_blk(h);
    if (h != target || h >= heap_span) return 1'b0;
    cur = target;
    put_block(cur, blk_size(cur), 1'b1);
    forever begin
      if (cur < 2 * TAG) break;
      t = cur - TAG;
      s = int'(tl_tag[t][11:0]);
      if (s + TAG > t) break;
      p = t - s - TAG;
      if (!blk_free(p)) break;
      put_block(p, cur + TAG + blk_size(cur) - p - TAG, 1'b1);
      cur = p;
    end
    forever begin
      n = next_blk(cur);
      if (n >= heap_span || !blk_free(n)) break;
      put_block(cur, n + TAG + blk_size(n) - cur - TAG, 1'b1);
    end
    return 1'b1;
  endfunction

  function automatic grant_t predict(bt_pkg::opcode_t op, int size, int addr);
    grant_t r;
    int g;
    bit ok;
    g = 0;
    if (op == bt_pkg::OP_ALLOC) ok = alloc_block(size, g);
    else ok = release_block(addr);
    if (!ok) g = 0;
    r.granted = g[11:0];
    r.ok = ok;
    if (op == bt_pkg::OP_ALLOC && ok) live_blocks.push_back(g[11:0]);
    if (op == bt_pkg::OP_FREE && ok)
      for (int i = 0; i < live_blocks.size(); i++)
        if (live_blocks[i] == addr[11:0]) begin
          live_blocks.delete(i);
          break;
        end
    return r;
  endfunction

  task automatic send_request(bt_pkg::opcode_t op, logic [11:0] size, logic [11:0] addr,
                              bit fixed = 1'b0, logic [11:0] fgrant = '0,
                              logic fok = 1'b0);
    grant_t r;
    while ($urandom_range(0, 99) < idle_pct) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.opcode       = op;
    req.request_size = size;
    req.user_address = addr;
    req.valid        = 1'b1;
    do @(posedge clk); while (!req.ready);
    r = predict(op, size, addr);
    if (fixed) begin
      r.granted = fgrant;
      r.ok = fok;
    end
    pending_grants.push_back(r);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req.valid = 1'b0;
    while (pending_grants.size() != 0) @(negedge clk);
  endtask

  task automatic write_heap_size(logic [bt_pkg::HEAP_SIZE_W-1:0] hs);
    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg.heap_size = hs;
    cfg.valid = 1'b1;
    do @(posedge clk); while (!cfg.ready);
    format_heap(hs);
    live_blocks.delete();
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic random_request();
    int pick;
    logic [11:0] sz, ad;
    pick = $urandom_range(0, 99);
    if (pick < 48) begin
      if ($urandom_range(0, 9) == 0) sz = 12'($urandom_range(0, 4095));
      else sz = 12'($urandom_range(0, 160));
      send_request(bt_pkg::OP_ALLOC, sz, 12'($urandom_range(0, 4095)));
    end else if (pick < 88 && live_blocks.size() != 0) begin
      ad = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
      send_request(bt_pkg::OP_FREE, 12'($urandom_range(0, 4095)), ad);
    end else begin
      ad = ($urandom_range(0, 3) == 0) ? 12'd0 : 12'($urandom_range(0, 4095));
      send_request(bt_pkg::OP_FREE, 12'($urandom_range(0, 4095)), ad);
    end
  endtask

  // Result side: random stalls plus a long hold-off on demand.
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    grant_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response: addr=%0d ok=%0b", rsp.granted_address, rsp.success);
      end else begin
        e = pending_grants.pop_front();
        if (rsp.granted_address !== e.granted || rsp.success !== e.ok) begin
          mismatches++;
          if (mismatches <= 10)
            $display("response mismatch: expected addr=%0d ok=%0b, got addr=%0d ok=%0b",
                     e.granted, e.ok, rsp.granted_address, rsp.success);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [bt_pkg::HEAP_SIZE_W-1:0] heap_plan [9];
    req.valid = 1'b0;
    req.opcode = bt_pkg::OP_ALLOC;
    req.request_size = '0;
    req.user_address = '0;
    cfg.valid = 1'b0;
    cfg.heap_size = '0;

    directed[0]  = '{bt_pkg::OP_ALLOC, 12'd0,    12'd0,    1'b1, 12'd4080, 1'b1};
    directed[1]  = '{bt_pkg::OP_ALLOC, 12'd4095, 12'd0,    1'b1, 12'd0,    1'b0};
    directed[2]  = '{bt_pkg::OP_FREE,  12'd0,    12'd0,    1'b1, 12'd0,    1'b0};
    directed[3]  = '{bt_pkg::OP_FREE,  12'd0,    12'd5,    1'b1, 12'd0,    1'b0};
    directed[4]  = '{bt_pkg::OP_FREE,  12'd4095, 12'd4095, 1'b1, 12'd0,    1'b0};
    directed[5]  = '{bt_pkg::OP_FREE,  12'd0,    12'd4080, 1'b1, 12'd0,    1'b1};
    directed[6]  = '{bt_pkg::OP_FREE,  12'd0,    12'd16,   1'b1, 12'd0,    1'b1};
    directed[7]  = '{bt_pkg::OP_ALLOC, 12'd4064, 12'd0,    1'b1, 12'd16,   1'b1};
    directed[8]  = '{bt_pkg::OP_ALLOC, 12'd1,    12'd0,    1'b1, 12'd0,    1'b0};
    directed[9]  = '{bt_pkg::OP_FREE,  12'd0,    12'd16,   1'b1, 12'd0,    1'b1};
    directed[10] = '{bt_pkg::OP_ALLOC, 12'd4033, 12'd0,    1'b0, 12'd0,    1'b0};
    directed[11] = '{bt_pkg::OP_FREE,  12'd0,    12'd16,   1'b0, 12'd0,    1'b0};
    directed[12] = '{bt_pkg::OP_ALLOC, 12'd100,  12'd0,    1'b0, 12'd0,    1'b0};
    directed[13] = '{bt_pkg::OP_ALLOC, 12'd200,  12'd0,    1'b0, 12'd0,    1'b0};
    directed[14] = '{bt_pkg::OP_ALLOC, 12'd50,   12'd0,    1'b0, 12'd0,    1'b0};
    directed[15] = '{bt_pkg::OP_FREE,  12'd0,    12'd3816, 1'b0, 12'd0,    1'b0};
    directed[16] = '{bt_pkg::OP_FREE,  12'd0,    12'd3982, 1'b0, 12'd0,    1'b0};
    directed[17] = '{bt_pkg::OP_FREE,  12'd0,    12'd3700, 1'b0, 12'd0,    1'b0};

    heap_plan = '{13'd8191, 13'd32, 13'd31, 13'd0, 13'd200, 13'd4096,
                  13'($urandom_range(32, 4096)), 13'd64, bt_pkg::HEAP_SIZE_RESET};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    format_heap(bt_pkg::HEAP_SIZE_RESET);

    for (int i = 0; i < N_DIRECTED; i++)
      send_request(directed[i].op, directed[i].size, directed[i].addr,
                   directed[i].fixed, directed[i].granted, directed[i].ok);
    for (int i = 0; i < 200; i++) random_request();

    for (int ph = 0; ph < 9; ph++) begin
      write_heap_size(heap_plan[ph]);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 57; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      if (ph == 5) hold_left = 400;
      send_request(bt_pkg::OP_ALLOC, 12'd0, 12'd0);
      for (int i = 0; i < 170; i++) begin
        if (ph == 6 && i == 85) wait_drained();
        random_request();
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
